@@ hdl/prc4_pkg.sv @@
// Package for the printable RC4 stream cipher unit.
// Shared types, the printable-range constants and the register indexes.
// No dependencies.
`default_nettype none

package prc4_pkg;

  // Printable ASCII window and its span
  localparam logic [7:0] LowPrint  = 8'd32;
  localparam logic [7:0] HighPrint = 8'd126;
  localparam logic [8:0] PrintSpan = 9'd95;
  localparam logic [8:0] TwoSpans  = 9'd190;
  localparam logic [8:0] ThreeSpans = 9'd285;

  // Last entry of the 256-entry permutation
  localparam logic [7:0] LastIndex = 8'hFF;
  localparam int unsigned PermDepth = 256;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1,
    CfgDir     = 2'd2
  } cfg_idx_t;

  // One classified item as it waits between front and back end
  typedef struct packed {
    logic [7:0] chr;
    logic       start;   // rerun key schedule before this byte
    logic       cipher;  // printable and a key is scheduled
  } item_t;

endpackage

`default_nettype wire

@@ hdl/printable_rc4_stream_cipher_unit.sv @@
// Printable RC4 stream cipher unit, top level.
// Each byte passes the queue and then the output register. Throughput: one plain
// byte per cycle while the output is not stalled; a ciphered byte runs dependent
// reads of S[i], S[j], S[t] before the next byte is taken. A message start first
// reruns the identity fill and the key schedule over all 256 permutation entries.
// Reset: synchronous active-low rst_n; key, direction, indices, key flag cleared.
`default_nettype none

module printable_rc4_stream_cipher_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_in
  input  wire         in_tuser,   // [0] message_start
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] char_out
  output logic        out_tuser,  // [0] ciphered
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  import prc4_pkg::*;

  logic [63:0] key_low_r, key_low_nxt;
  logic [63:0] key_high_r, key_high_nxt;
  logic        dir_r, dir_nxt;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  assign cfg_ready = 1'b1;

  // Register write decode
  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    dir_nxt      = dir_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CfgKeyLow:  key_low_nxt  = cfg_data;
        CfgKeyHigh: key_high_nxt = cfg_data;
        CfgDir:     dir_nxt      = cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      dir_r      <= 1'b0;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
      dir_r      <= dir_nxt;
    end
  end

  prc4_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_start   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  prc4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  prc4_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .key       ({key_high_r, key_low_r}),
    .dir       (dir_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_ciph  (out_tuser)
  );

endmodule

`default_nettype wire

@@ hdl/prc4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module prc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/prc4_front.sv @@
// Front end: accepts input items and classifies them for the back end.
// Tracks whether any key schedule has been requested yet.
// Depends on prc4_pkg.
`default_nettype none

module prc4_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_char,
  input  wire                 in_start,
  output logic                push_valid,
  input  wire                 push_ready,
  output prc4_pkg::item_t     push_item
);

  import prc4_pkg::*;

  logic keyed_r, keyed_nxt;
  logic printable;
  logic accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Printable bytes are ciphered once a schedule has run or runs now
  assign printable = (in_char >= LowPrint) && (in_char <= HighPrint);

  always_comb begin
    push_item.chr    = in_char;
    push_item.start  = in_start;
    push_item.cipher = printable && (keyed_r || in_start);
  end

  // Sticky flag: set by the first accepted message start
  assign keyed_nxt = keyed_r || (accept && in_start);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r <= 1'b0;
    end else begin
      keyed_r <= keyed_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/prc4_queue.sv @@
// Short FIFO of classified items between front and back end.
// Each side stalls on its own; head entry is shown while not empty.
// Depends on prc4_pkg.
`default_nettype none

module prc4_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  wire prc4_pkg::item_t  push_item,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output prc4_pkg::item_t       pop_item
);

  import prc4_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  item_t           q_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != Full);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/prc4_core.sv @@
// Back end: key schedule and keystream sequencer over the permutation RAM,
// printable wrap arithmetic and the output register.
// Depends on prc4_pkg and prc4_ram.
`default_nettype none

module prc4_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_ready,
  input  wire prc4_pkg::item_t  q_item,
  input  wire  [127:0]          key,
  input  wire                   dir,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_char,
  output logic                  out_ciph
);

  import prc4_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_INIT    = 10'b00_0000_0010,
    S_KS_RD_A = 10'b00_0000_0100,
    S_KS_RD_B = 10'b00_0000_1000,
    S_KS_WR_A = 10'b00_0001_0000,
    S_KS_WR_B = 10'b00_0010_0000,
    S_PG_RD_I = 10'b00_0100_0000,
    S_PG_RD_J = 10'b00_1000_0000,
    S_PG_WR_I = 10'b01_0000_0000,
    S_PG_FIN  = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  item_t      cur_r, cur_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] b_r, b_nxt;
  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [7:0] si_r, si_nxt;
  logic [7:0] sj_r, sj_nxt;
  logic [7:0] t_r, t_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_ciph_r, out_ciph_nxt;

  logic       ram_we;
  logic [7:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  logic       out_free;
  logic [7:0] i_inc;
  logic [7:0] key_byte;
  logic [7:0] kbyte;
  logic [6:0] off;
  logic [8:0] sum;
  logic [8:0] red1;
  logic [6:0] red2;
  logic [7:0] wrapped;

  prc4_ram #(
    .WIDTH (8),
    .DEPTH (PermDepth)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_ciph  = out_ciph_r;
  assign out_free  = !out_valid_r || out_ready;
  assign i_inc     = i_r + 8'd1;
  assign key_byte  = key[{cnt_r[3:0], 3'b000} +: 8];

  // Keystream byte: forward the swapped values when the final index hits them
  always_comb begin
    if (t_r == j_r) begin
      kbyte = si_r;
    end else if (t_r == i_r) begin
      kbyte = sj_r;
    end else begin
      kbyte = ram_rdata;
    end
  end

  // Wrap back into the printable window, mod 95
  always_comb begin
    off = 7'(cur_r.chr - LowPrint);
    if (dir) begin
      sum = {2'b00, off} + ThreeSpans - {1'b0, kbyte};
    end else begin
      sum = {2'b00, off} + {1'b0, kbyte};
    end
    red1    = (sum >= TwoSpans) ? sum - TwoSpans : sum;
    red2    = (red1 >= PrintSpan) ? 7'(red1 - PrintSpan) : red1[6:0];
    wrapped = {1'b0, red2} + LowPrint;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    b_nxt         = b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_ciph_nxt  = out_ciph_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = cnt_r;
    ram_raddr     = cnt_r;
    q_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Take an item only when its result has a free slot at the end
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          cur_nxt = q_item;
          if (q_item.start) begin
            cnt_nxt   = '0;
            state_nxt = S_INIT;
          end else if (q_item.cipher) begin
            i_nxt     = i_inc;
            ram_raddr = i_inc;
            state_nxt = S_PG_RD_J;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = q_item.chr;
            out_ciph_nxt  = 1'b0;
          end
        end
      end
      S_INIT: begin
        // Identity fill, one entry a cycle
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = cnt_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == LastIndex) begin
          b_nxt     = '0;
          state_nxt = S_KS_RD_A;
        end
      end
      S_KS_RD_A: begin
        ram_raddr = cnt_r;
        state_nxt = S_KS_RD_B;
      end
      S_KS_RD_B: begin
        si_nxt    = ram_rdata;
        b_nxt     = b_r + ram_rdata + key_byte;
        ram_raddr = b_nxt;
        state_nxt = S_KS_WR_A;
      end
      S_KS_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = ram_rdata;
        state_nxt = S_KS_WR_B;
      end
      S_KS_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = b_r;
        ram_wdata = si_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == LastIndex) begin
          i_nxt = '0;
          j_nxt = '0;
          if (cur_r.cipher) begin
            state_nxt = S_PG_RD_I;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = cur_r.chr;
            out_ciph_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_KS_RD_A;
        end
      end
      S_PG_RD_I: begin
        i_nxt     = i_inc;
        ram_raddr = i_inc;
        state_nxt = S_PG_RD_J;
      end
      S_PG_RD_J: begin
        si_nxt    = ram_rdata;
        j_nxt     = j_r + ram_rdata;
        ram_raddr = j_nxt;
        state_nxt = S_PG_WR_I;
      end
      S_PG_WR_I: begin
        // Swap first half, and look up the output index meanwhile
        sj_nxt    = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
        t_nxt     = si_r + ram_rdata;
        ram_raddr = t_nxt;
        state_nxt = S_PG_FIN;
      end
      S_PG_FIN: begin
        ram_we        = 1'b1;
        ram_waddr     = j_r;
        ram_wdata     = si_r;
        out_valid_nxt = 1'b1;
        out_char_nxt  = wrapped;
        out_ciph_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    b_r        <= b_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    out_char_r <= out_char_nxt;
    out_ciph_r <= out_ciph_nxt;
  end

endmodule

`default_nettype wire
